>>> sv/i2ctrm_pkg.sv
// ----------------------------------------------------------------------------
// i2ctrm_pkg
// shared types, codes and sizes of the i2c target register map
// ----------------------------------------------------------------------------
package i2ctrm_pkg;

    // number of bytes in the register store
    localparam int MAP_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    // pointer and map size are nine bits wide
    localparam int PTR_W = 9;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [2:0]        mode_t;
    typedef logic [1:0]        status_t;

    // bus and application event codes
    localparam mode_t MODE_RD_REQ = 3'd0;
    localparam mode_t MODE_RX     = 3'd1;
    localparam mode_t MODE_STOP   = 3'd2;
    localparam mode_t MODE_LWR    = 3'd3;
    localparam mode_t MODE_LRD    = 3'd4;

    // result status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_RD_RANGE = 2'd1;
    localparam status_t ST_WR_RANGE = 2'd2;

    localparam ptr_t MAP_SIZE_RESET = ptr_t'(MAP_DEPTH);

endpackage

>>> sv/i2ctrm_if.sv
// ----------------------------------------------------------------------------
// i2ctrm_in_if / i2ctrm_out_if
// valid/ready channels carrying bus events and their results
// ----------------------------------------------------------------------------
interface i2ctrm_in_if
    import i2ctrm_pkg::*;
    ();
    logic       valid;
    logic       ready;
    mode_t      mode;
    logic [7:0] data_byte;
    logic [7:0] local_index;

    modport source (output valid, output mode, output data_byte, output local_index,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input local_index,
                    output ready);
endinterface

interface i2ctrm_out_if
    import i2ctrm_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    status_t    status;

    modport source (output valid, output out_byte, output out_valid, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input status,
                    output ready);
endinterface

>>> sv/i2ctrm_ram.sv
// ----------------------------------------------------------------------------
// i2ctrm_ram
// generic single-port ram, registered read data held until the next read
// ----------------------------------------------------------------------------
module i2ctrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/i2c_target_register_map.sv
// ----------------------------------------------------------------------------
// i2c_target_register_map
// register-map side of an i2c target with auto-incrementing pointer
// ----------------------------------------------------------------------------
// One event is taken per transfer on req and exactly one result leaves on rsp
// for every event, in order. A new event can be taken every clock cycle while
// rsp is not blocked; each result passes the middle stage, which waits for the
// registered read port of the byte store, and then the result register. The
// first byte received after reset or a stop loads the pointer; later received
// bytes are written at the pointer and master read requests return the byte
// at the pointer, both advancing it. Local reads and writes reach the store by
// index. Accesses at or past the configured map size are dropped (status 2) or
// return nothing (status 1); a master read past the end also clamps the
// pointer to the last entry. The store reads as zero after reset: each byte
// has a valid flag that reset clears, so no clearing pass is needed and events
// are taken at once. map_size must be written through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this. Values
// above the store depth act as the depth, and zero acts as one.
// ----------------------------------------------------------------------------
module i2c_target_register_map
    import i2ctrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    i2ctrm_in_if.sink          req,
    i2ctrm_out_if.source       rsp,
    input  logic               cfg_we,
    input  logic [PTR_W-1:0]   cfg_wdata
);

    // configuration and architectural state
    ptr_t    map_size_reg;
    ptr_t    pointer_reg;
    ptr_t    pointer_next;
    logic    idx_loaded_reg;
    logic    idx_loaded_next;
    logic    entry_valid_reg [MAP_DEPTH];

    // middle stage: waits for the ram read data
    logic    s1_valid_reg;
    logic    s1_rd_reg;
    logic    s1_vbit_reg;
    status_t s1_status_reg;

    // result register
    logic       rsp_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_dv_reg;
    status_t    out_status_reg;

    // event decode
    ptr_t    size;
    logic    accept;
    logic    s1_adv;
    logic    wr_hit;
    logic    rd_hit;
    addr_t   ram_addr;
    status_t status_c;
    logic [7:0] ram_rdata;

    // effective map size: saturate to the depth, zero counts as one
    always_comb
    begin
        if (map_size_reg > MAP_SIZE_RESET)
        begin
            size = MAP_SIZE_RESET;
        end
        else if (map_size_reg == '0)
        begin
            size = ptr_t'(1);
        end
        else
        begin
            size = map_size_reg;
        end
    end

    // the middle stage moves on when the result register is free or drains
    assign s1_adv    = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    // next pointer, flag, ram access and status for the event on req
    always_comb
    begin
        pointer_next    = pointer_reg;
        idx_loaded_next = idx_loaded_reg;
        wr_hit          = 1'b0;
        rd_hit          = 1'b0;
        ram_addr        = pointer_reg[ADDR_W-1:0];
        status_c        = ST_OK;
        case (req.mode)
            MODE_RD_REQ:
            begin
                if (pointer_reg >= size)
                begin
                    // read past the end: clamp to the last entry, send nothing
                    pointer_next = size - ptr_t'(1);
                    status_c     = ST_RD_RANGE;
                end
                else
                begin
                    rd_hit       = 1'b1;
                    pointer_next = pointer_reg + ptr_t'(1);
                end
            end
            MODE_RX:
            begin
                if (!idx_loaded_reg)
                begin
                    // first byte after a stop is the register index
                    pointer_next    = ptr_t'(req.data_byte);
                    idx_loaded_next = 1'b1;
                end
                else if (pointer_reg < size)
                begin
                    wr_hit       = 1'b1;
                    pointer_next = pointer_reg + ptr_t'(1);
                end
                else
                begin
                    status_c = ST_WR_RANGE;
                end
            end
            MODE_STOP:
            begin
                idx_loaded_next = 1'b0;
            end
            MODE_LWR:
            begin
                ram_addr = req.local_index[ADDR_W-1:0];
                if (ptr_t'(req.local_index) < size)
                begin
                    wr_hit = 1'b1;
                end
                else
                begin
                    status_c = ST_WR_RANGE;
                end
            end
            MODE_LRD:
            begin
                ram_addr = req.local_index[ADDR_W-1:0];
                if (ptr_t'(req.local_index) < size)
                begin
                    rd_hit = 1'b1;
                end
                else
                begin
                    status_c = ST_RD_RANGE;
                end
            end
            default:
            begin
                // unused codes leave the state alone
                status_c = ST_OK;
            end
        endcase
    end

    // byte store
    i2ctrm_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && wr_hit),
        .re    (accept && rd_hit),
        .addr  (ram_addr),
        .wdata (req.data_byte),
        .rdata (ram_rdata)
    );

    // configuration, pointer, index flag and per-byte valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg   <= MAP_SIZE_RESET;
            pointer_reg    <= '0;
            idx_loaded_reg <= 1'b0;
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                map_size_reg <= cfg_wdata;
            end
            if (accept)
            begin
                pointer_reg    <= pointer_next;
                idx_loaded_reg <= idx_loaded_next;
                if (wr_hit)
                begin
                    entry_valid_reg[ram_addr] <= 1'b1;
                end
            end
        end
    end

    // middle stage and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg     <= rd_hit;
            s1_vbit_reg   <= entry_valid_reg[ram_addr];
            s1_status_reg <= status_c;
        end
        if (s1_valid_reg && s1_adv)
        begin
            // a byte never written since reset reads as zero
            out_byte_reg   <= (s1_rd_reg && s1_vbit_reg) ? ram_rdata : 8'd0;
            out_dv_reg     <= s1_rd_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_byte  = out_byte_reg;
    assign rsp.out_valid = out_dv_reg;
    assign rsp.status    = out_status_reg;

`ifndef NO_ASSERTIONS
    // req only stalls when both internal stages are full and rsp is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && rsp_valid_reg && !rsp.ready))
        else $error("req stalled without a blocked result");

    // pointer never goes past one beyond the last entry of the store
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        pointer_reg <= MAP_SIZE_RESET)
        else $error("pointer out of range");

    // a result with no data carries a zero byte
    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.out_valid) |-> (rsp.out_byte == 8'd0))
        else $error("non-zero byte without data");

    // a stop clears the index flag
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.mode == MODE_STOP)) |=> !idx_loaded_reg)
        else $error("index flag survived a stop");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i2c target register map
// ----------------------------------------------------------------------------
// A directed table covers the corners first: store contents after reset, the
// index byte, pointer runs past the end, clamping, dropped writes, local
// accesses out of range, stop and the spare event codes. After that come
// random phases. Each phase sets a new map size and its own idling style, and
// is built mostly from stop/index/burst transactions with random data. Every
// accepted event is run through a local copy of the map behaviour, and each
// result transfer is checked field by field against the oldest pending
// expectation.
// ----------------------------------------------------------------------------
module tb;
    import i2ctrm_pkg::*;

    // event codes the block ignores
    localparam mode_t MODE_SPARE5 = 3'd5;
    localparam mode_t MODE_SPARE6 = 3'd6;
    localparam mode_t MODE_SPARE7 = 3'd7;

    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        status_t    status;
    } map_result_t;

    typedef enum logic { ROW_EVENT, ROW_SIZE } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        ptr_t        size;
        mode_t       mode;
        logic [7:0]  data;
        logic [7:0]  lidx;
        logic        typed;
        map_result_t want;
    } stim_row_t;

    // directed walk; rows with typed set carry a hand-written result,
    // the rest take the result worked out by target_map_event
    localparam int N_ROWS = 27;
    stim_row_t dir_tab [N_ROWS] = '{
        // store reads zero after reset, pointer starts at zero
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b1, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_LRD,    8'h00, 8'hFF, 1'b1, '{8'h00, 1'b1, ST_OK}},
        // index byte at the top of the map, then a write that pushes it past the end
        '{ROW_EVENT, 9'd0, MODE_RX,     8'hFF, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RX,     8'hA5, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RX,     8'h5A, 8'h00, 1'b1, '{8'h00, 1'b0, ST_WR_RANGE}},
        // read past the end clamps, the next read returns the last byte
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, ST_RD_RANGE}},
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_STOP,   8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RX,     8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RX,     8'hFF, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_LWR,    8'h81, 8'h7E, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_LRD,    8'h00, 8'h7E, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        // spare codes give an all-zero result
        '{ROW_EVENT, 9'd0, MODE_SPARE5, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_SPARE6, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_SPARE7, 8'hFF, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK}},
        // size zero behaves as a one-byte map
        '{ROW_SIZE,  9'd0, MODE_STOP,   8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_LWR,    8'h3C, 8'h01, 1'b1, '{8'h00, 1'b0, ST_WR_RANGE}},
        '{ROW_EVENT, 9'd0, MODE_LRD,    8'h00, 8'hFF, 1'b1, '{8'h00, 1'b0, ST_RD_RANGE}},
        '{ROW_EVENT, 9'd0, MODE_LRD,    8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_STOP,   8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        // index byte beyond the size is still taken
        '{ROW_EVENT, 9'd0, MODE_RX,     8'h10, 8'h00, 1'b1, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_RX,     8'h77, 8'h00, 1'b1, '{8'h00, 1'b0, ST_WR_RANGE}},
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b1, '{8'h00, 1'b0, ST_RD_RANGE}},
        '{ROW_EVENT, 9'd0, MODE_RD_REQ, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        // oversized value saturates to the full depth
        '{ROW_SIZE,  9'h1FF, MODE_STOP, 8'h00, 8'h00, 1'b0, '{8'h00, 1'b0, ST_OK}},
        '{ROW_EVENT, 9'd0, MODE_LRD,    8'h00, 8'hFF, 1'b0, '{8'h00, 1'b0, ST_OK}}
    };

    // map size for each random phase, extremes included
    ptr_t phase_sizes [N_PHASES] = '{9'd256, 9'd1, 9'd511, 9'd2, 9'd255, 9'd0, 9'd37, 9'd256};

    logic clk;
    logic rst_n;
    logic cfg_we;
    ptr_t cfg_wdata;

    i2ctrm_in_if  req_ch ();
    i2ctrm_out_if rsp_ch ();

    i2c_target_register_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // local copy of the map state
    logic [7:0]  map_store [MAP_DEPTH];
    ptr_t        map_ptr;
    logic        index_held;
    ptr_t        size_reg;

    map_result_t pending_results [$];
    map_result_t rsp_want;

    int mismatches    = 0;
    int cycle_count   = 0;
    int events_sent   = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // size as the block uses it: saturated to the depth, zero taken as one
    function automatic int unsigned usable_size();
        int unsigned s;
        s = size_reg;
        if (s > MAP_DEPTH)
            s = MAP_DEPTH;
        if (s == 0)
            s = 1;
        return s;
    endfunction

    // applies one event to the local map state and returns its result
    function automatic map_result_t target_map_event(mode_t m, logic [7:0] d, logic [7:0] li);
        map_result_t r;
        int unsigned lim;
        r = '0;
        r.status = ST_OK;
        lim = usable_size();
        case (m)
            MODE_RD_REQ:
            begin
                if (map_ptr >= lim)
                begin
                    map_ptr  = ptr_t'(lim - 1);
                    r.status = ST_RD_RANGE;
                end
                else
                begin
                    r.out_byte  = map_store[map_ptr[7:0]];
                    r.out_valid = 1'b1;
                    map_ptr     = map_ptr + 1'b1;
                end
            end
            MODE_RX:
            begin
                if (!index_held)
                begin
                    map_ptr    = {1'b0, d};
                    index_held = 1'b1;
                end
                else if (map_ptr < lim)
                begin
                    map_store[map_ptr[7:0]] = d;
                    map_ptr = map_ptr + 1'b1;
                end
                else
                    r.status = ST_WR_RANGE;
            end
            MODE_STOP:
                index_held = 1'b0;
            MODE_LWR:
            begin
                if (li < lim)
                    map_store[li] = d;
                else
                    r.status = ST_WR_RANGE;
            end
            MODE_LRD:
            begin
                if (li < lim)
                begin
                    r.out_byte  = map_store[li];
                    r.out_valid = 1'b1;
                end
                else
                    r.status = ST_RD_RANGE;
            end
            default: ;
        endcase
        return r;
    endfunction

    // index biased towards the live map and its last entry
    function automatic logic [7:0] pick_index();
        int unsigned lim;
        lim = usable_size();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1, 2:    return 8'($urandom_range(0, lim - 1));
            default: return (lim > 255) ? 8'hFF : 8'(lim - $urandom_range(0, 1));
        endcase
    endfunction

    // offers one event and waits for its transfer; a typed row overrides the
    // computed result with the one written in the table
    task automatic send_event(mode_t m, logic [7:0] d, logic [7:0] li,
                              logic typed = 1'b0, map_result_t want = '0);
        map_result_t r;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= m;
        req_ch.data_byte   <= d;
        req_ch.local_index <= li;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        r = target_map_event(m, d, li);
        pending_results.push_back(typed ? want : r);
        if (m <= MODE_LRD)
            events_sent++;
    endtask

    // stops offering and waits until every result has left the block
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_map_size(ptr_t v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg   = v;
    endtask

    // result side: checks each transfer and drives ready, with a long
    // hold-off whenever the stimulus side asks for one
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: byte %02h valid %0d status %0d",
                             rsp_ch.out_byte, rsp_ch.out_valid, rsp_ch.status);
            end
            else
            begin
                rsp_want = pending_results.pop_front();
                if (rsp_ch.out_byte !== rsp_want.out_byte ||
                    rsp_ch.out_valid !== rsp_want.out_valid ||
                    rsp_ch.status !== rsp_want.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: want byte %02h valid %0d status %0d,",
                                  " got byte %02h valid %0d status %0d"},
                                 rsp_want.out_byte, rsp_want.out_valid, rsp_want.status,
                                 rsp_ch.out_byte, rsp_ch.out_valid, rsp_ch.status);
                end
            end
        end
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int   pick;
        int   n;
        int   style;
        int   start;
        mode_t m;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = MAP_SIZE_RESET;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_STOP;
        req_ch.data_byte   = 8'h00;
        req_ch.local_index = 8'h00;
        foreach (map_store[i])
            map_store[i] = 8'h00;
        map_ptr    = '0;
        index_held = 1'b0;
        size_reg   = MAP_SIZE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners, no idling
        for (int i = 0; i < N_ROWS; i++)
        begin
            if (dir_tab[i].kind == ROW_SIZE)
                set_map_size(dir_tab[i].size);
            else
                send_event(dir_tab[i].mode, dir_tab[i].data, dir_tab[i].lidx,
                           dir_tab[i].typed, dir_tab[i].want);
        end

        // random phases, each with its own size and idling style
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_map_size(phase_sizes[ph]);
            case (ph % 4)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 59; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 59; end
                default: begin snd_idle_pct = 36; rcv_stall_pct = 36; end
            endcase
            // back-pressure: results held off while events keep coming
            if (ph == 0)
                hold_token++;
            start = events_sent;
            while (events_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // stop, index byte, then a burst of writes, reads or both
                    send_event(MODE_STOP, 8'($urandom), 8'($urandom));
                    send_event(MODE_RX, pick_index(), 8'($urandom));
                    n     = $urandom_range(1, 8);
                    style = $urandom_range(0, 2);
                    for (int k = 0; k < n; k++)
                    begin
                        case (style)
                            0:       m = MODE_RX;
                            1:       m = MODE_RD_REQ;
                            default: m = $urandom_range(0, 1) ? MODE_RX : MODE_RD_REQ;
                        endcase
                        send_event(m, 8'($urandom), 8'($urandom));
                    end
                end
                else if (pick < 80)
                    send_event($urandom_range(0, 1) ? MODE_LWR : MODE_LRD,
                               8'($urandom), pick_index());
                else if (pick < 90)
                    send_event(mode_t'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
                else
                    // bus traffic with no stop in front of it
                    send_event($urandom_range(0, 1) ? MODE_RX : MODE_RD_REQ,
                               8'($urandom), 8'($urandom));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
